/* hdl/jsu_pkg.sv */
// shared types, character codes and decode helpers for the json string unescaper
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_WAIT = 2'd0,
    MODE_TEXT = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_U = 8'h75;

  localparam logic [15:0] UTF8_LIM1 = 16'h0080;
  localparam logic [15:0] UTF8_LIM2 = 16'h0800;
  localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0] UTF8_CONT = 8'h80;
  localparam logic [5:0] UTF8_MASK = 6'h3F;

  typedef struct packed {
    mode_t       mode;
    logic [1:0]  hex_count;
    logic [15:0] code_point;
  } state_t;

  // results caused by one request, bytes[0] goes out first
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            bval;
    logic            str_end;
    logic            bad;
  } burst_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c inside {[8'h30:8'h39]}) v = c[3:0];
    else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic [7:0] escape_map(input logic [7:0] c);
    logic [7:0] v;
    case (c)
      8'h62:   v = 8'h08;
      8'h66:   v = 8'h0C;
      8'h6E:   v = 8'h0A;
      8'h72:   v = 8'h0D;
      8'h74:   v = 8'h09;
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

/* hdl/jsu_decode.sv */
// one-step decode of a source byte into next parser state and up to three results
module jsu_decode import jsu_pkg::*; (
  input  state_t     cur,
  input  logic [7:0] in_byte,
  input  logic       source_end,
  output state_t     nxt,
  output burst_t     burst
);

  logic [15:0]     cp_new;
  logic [2:0][7:0] b;
  logic [1:0]      n;
  logic            fin;
  logic            bad;

  assign cp_new = {cur.code_point[11:0], hex_value(in_byte)};

  always_comb begin
    nxt = cur;
    b   = '0;
    n   = 2'd0;
    fin = 1'b0;
    bad = 1'b0;
    case (cur.mode)
      MODE_WAIT: begin
        if (in_byte == CH_QUOTE) begin
          if (source_end) fin = 1'b1;
          else nxt.mode = MODE_TEXT;
        end else if (in_byte inside {CH_SPACE, CH_TAB, CH_LF, CH_CR}) begin
          bad = source_end;
        end else begin
          bad = 1'b1;
        end
      end
      MODE_TEXT: begin
        if (in_byte == CH_QUOTE) begin
          fin = 1'b1;
        end else if (in_byte == CH_BSLASH) begin
          if (source_end) fin = 1'b1;
          else nxt.mode = MODE_ESC;
        end else begin
          b[0] = in_byte;
          n    = 2'd1;
          fin  = source_end;
        end
      end
      MODE_ESC: begin
        if (in_byte == CH_U) begin
          if (source_end) begin
            n   = 2'd1;
            fin = 1'b1;
          end else begin
            nxt.mode       = MODE_HEX;
            nxt.hex_count  = 2'd0;
            nxt.code_point = '0;
          end
        end else begin
          b[0] = escape_map(in_byte);
          n    = 2'd1;
          if (source_end) fin = 1'b1;
          else nxt.mode = MODE_TEXT;
        end
      end
      MODE_HEX: begin
        nxt.code_point = cp_new;
        if (cur.hex_count == 2'd3 || source_end) begin
          if (cp_new < UTF8_LIM1) begin
            b[0] = cp_new[7:0];
            n    = 2'd1;
          end else if (cp_new < UTF8_LIM2) begin
            b[0] = UTF8_LEAD2 | {3'b000, cp_new[10:6]};
            b[1] = UTF8_CONT | {2'b00, cp_new[5:0] & UTF8_MASK};
            n    = 2'd2;
          end else begin
            b[0] = UTF8_LEAD3 | {4'b0000, cp_new[15:12]};
            b[1] = UTF8_CONT | {2'b00, cp_new[11:6] & UTF8_MASK};
            b[2] = UTF8_CONT | {2'b00, cp_new[5:0] & UTF8_MASK};
            n    = 2'd3;
          end
          nxt.hex_count  = 2'd0;
          nxt.code_point = '0;
          if (source_end) fin = 1'b1;
          else nxt.mode = MODE_TEXT;
        end else begin
          nxt.hex_count = cur.hex_count + 2'd1;
        end
      end
      default: nxt = cur;
    endcase
    if (fin || bad) begin
      nxt.mode       = MODE_WAIT;
      nxt.hex_count  = 2'd0;
      nxt.code_point = '0;
    end
  end

  always_comb begin
    burst.bytes   = b;
    burst.bval    = (n != 2'd0);
    burst.cnt     = (n != 2'd0) ? n : {1'b0, fin | bad};
    burst.str_end = fin;
    burst.bad     = bad;
  end

endmodule

/* hdl/json_string_unescaper.sv */
// top level: json string unescaper with stream input and result channels
// source text enters one byte per request on in_tdata, in_tlast marks the
// final source byte. each byte is decoded in the cycle it is accepted and
// its results (zero to three) are loaded into a result register; they leave
// on the out_ channel one per cycle while ready, out_tlast on a byte's last.
// out_tuser carries byte_valid, string_end and not_string.
// the first result of a byte is presented in the cycle after it is accepted.
// throughput: one byte per cycle while each byte yields at most one result and
// out_tready is high; a byte with more results holds in_tready low until its
// last result is being taken, the single result register draining one entry
// per cycle while out_tready is high. in_tready is high while the register is
// empty or its last entry is being taken, so a silent byte (whitespace, an
// opening quote, backslash, non-final hex digit) never stalls the input.
// reset (rst_n low, synchronous) drops pending results and returns the
// parser to waiting for an opening quote.
// a stalled receiver holds the current result and, once the register is
// full, holds in_tready low; no result is lost.
module json_string_unescaper import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // in_byte
  input  logic       in_tlast,   // source_end
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic [2:0] out_tuser,  // byte_valid, string_end, not_string
  output logic       out_tlast   // run_last
);

  state_t     state_r, state_nxt;
  burst_t     burst_r, burst_nxt;
  logic [1:0] rem_r, rem_nxt;
  logic [1:0] idx_r, idx_nxt;
  state_t     dec_state;
  burst_t     dec_burst;
  logic       in_fire;
  logic       out_fire;
  logic       is_last;
  logic [7:0] cur_byte;

  jsu_decode u_decode (
    .cur        (state_r),
    .in_byte    (in_tdata),
    .source_end (in_tlast),
    .nxt        (dec_state),
    .burst      (dec_burst)
  );

  assign is_last   = (rem_r == 2'd1);
  assign in_tready = (rem_r == 2'd0) || (is_last && out_tready);
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  always_comb begin
    state_nxt = state_r;
    burst_nxt = burst_r;
    rem_nxt   = rem_r;
    idx_nxt   = idx_r;
    if (in_fire) begin
      state_nxt = dec_state;
      burst_nxt = dec_burst;
      rem_nxt   = dec_burst.cnt;
      idx_nxt   = 2'd0;
    end else if (out_fire) begin
      rem_nxt = rem_r - 2'd1;
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{mode: MODE_WAIT, hex_count: 2'd0, code_point: 16'd0};
      rem_r   <= 2'd0;
      idx_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      rem_r   <= rem_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    burst_r <= burst_nxt;
  end

  always_comb begin
    case (idx_r)
      2'd0:    cur_byte = burst_r.bytes[0];
      2'd1:    cur_byte = burst_r.bytes[1];
      2'd2:    cur_byte = burst_r.bytes[2];
      default: cur_byte = 8'h00;
    endcase
  end

  assign out_tvalid = (rem_r != 2'd0);
  assign out_tdata  = cur_byte;
  assign out_tlast  = is_last;
  assign out_tuser  = {burst_r.bad, burst_r.str_end && is_last, burst_r.bval};

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r != 2'd3 || idx_r == 2'd0)
    else $error("result register count and index disagree");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && dec_burst.cnt != 2'd0) |=> out_tvalid)
    else $error("loaded results not presented");

  a_bad_form: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2]) |-> (!out_tuser[0] && !out_tuser[1] && out_tlast))
    else $error("not_string result malformed");

  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1]) |-> out_tlast)
    else $error("string_end off the last result of a byte");

  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r >= 2'd2) |-> !in_tready)
    else $error("input taken while results still queued");

endmodule
